@@ hdl/asw_pkg.sv @@
// shared constants, mode codes and the tanh table for the waveshaper
`timescale 1ns / 1ps
`default_nettype none
package asw_pkg;
	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS = 20;
	localparam int TANH_LAST = 32;

	typedef enum logic [1:0] {
		MODE_KNEE = 2'd0,
		MODE_CLIP = 2'd1,
		MODE_TUBE = 2'd2,
		MODE_TAPE = 2'd3
	} mode_t;

	// 0.8 * tanh(k / 8) in units of 2^-16
	function automatic logic [15:0] tanh_at(input logic [5:0] k);
		logic [15:0] v;
		case (k)
			6'd0: v = 16'd0;
			6'd1: v = 16'd6520;
			6'd2: v = 16'd12841;
			6'd3: v = 16'd18788;
			6'd4: v = 16'd24228;
			6'd5: v = 16'd29077;
			6'd6: v = 16'd33300;
			6'd7: v = 16'd36904;
			6'd8: v = 16'd39929;
			6'd9: v = 16'd42431;
			6'd10: v = 16'd44474;
			6'd11: v = 16'd46128;
			6'd12: v = 16'd47456;
			6'd13: v = 16'd48517;
			6'd14: v = 16'd49355;
			6'd15: v = 16'd50019;
			6'd16: v = 16'd50543;
			6'd17: v = 16'd50954;
			6'd18: v = 16'd51277;
			6'd19: v = 16'd51529;
			6'd20: v = 16'd51727;
			6'd21: v = 16'd51881;
			6'd22: v = 16'd52002;
			6'd23: v = 16'd52096;
			6'd24: v = 16'd52170;
			6'd25: v = 16'd52227;
			6'd26: v = 16'd52271;
			6'd27: v = 16'd52306;
			6'd28: v = 16'd52333;
			6'd29: v = 16'd52354;
			6'd30: v = 16'd52371;
			6'd31: v = 16'd52384;
			default: v = 16'd52394;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

@@ hdl/asw_ifs.sv @@
// stream and configuration channel interfaces of the waveshaper
`timescale 1ns / 1ps
`default_nettype none
interface asw_in_if import asw_pkg::*; #(parameter int W = SAMPLE_BITS);
	logic valid;
	logic ready;
	logic signed [W-1:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface asw_out_if import asw_pkg::*; #(parameter int W = SAMPLE_BITS);
	logic valid;
	logic ready;
	logic signed [W-1:0] sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

interface asw_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] curve_mode;
	modport source (output valid, output curve_mode, input ready);
	modport sink (input valid, input curve_mode, output ready);
endinterface
`default_nettype wire

@@ hdl/audio_saturation_waveshaper.sv @@
// audio saturation waveshaper: four odd transfer curves on a signed fixed-point stream
//
// src carries one signed sample per beat, dst one shaped sample per beat, both
// valid/ready. cfg writes the two-bit curve mode (always ready); write it only
// while no sample is in flight. the mode is sampled with each input beat.
// the soft-knee divider sets the pipeline depth, one quotient bit per stage.
// one beat is taken every cycle unless dst stalls. when dst stalls the
// whole pipeline holds and src.ready drops in the same cycle, so nothing is
// lost or repeated. reset empties the pipeline and sets the mode to soft knee.
//
// stages: magnitude, curve prep and products, tape rounding and knee divisor,
// cubic product, divide-by-three product, curve select, divider, output.
`timescale 1ns / 1ps
`default_nettype none
module audio_saturation_waveshaper import asw_pkg::*; #(
	parameter int SAMPLE_BITS = asw_pkg::SAMPLE_BITS,
	parameter int FRAC_BITS = asw_pkg::FRAC_BITS
) (
	input wire clk,
	input wire arst_n,
	asw_in_if.sink src,
	asw_out_if.source dst,
	asw_cfg_if.sink cfg
);
	localparam int SB = SAMPLE_BITS;
	localparam int F = FRAC_BITS;
	localparam longint unsigned ONE = 64'd1 << F;
	localparam longint unsigned KNEE_T = (7 * ONE + 5) / 10;
	localparam longint unsigned CLIP_C = (19 * ONE + 10) / 20;
	localparam longint unsigned TUBE_MAX = (2 * ONE + 1) / 3;
	localparam longint unsigned OUT_MAX = KNEE_T + ONE / 3;
	localparam int K3 = ((F + 1) % 2 == 1) ? F + 1 : F + 2;
	localparam longint unsigned M3 = ((64'd1 << K3) + 1) / 3;
	localparam int NQ = F - 1;
	localparam int DW = SB + 2;
	localparam int RW = SB + F + 2;
	localparam int AW = F + 17;

	mode_t curve_mode_q;
	logic out_vld_q;
	logic signed [SB-1:0] out_q;
	logic adv;

	assign adv = !out_vld_q || dst.ready;
	assign src.ready = adv;
	assign cfg.ready = 1'b1;
	assign dst.valid = out_vld_q;
	assign dst.sample_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= MODE_KNEE;
		end else if (cfg.valid) begin
			curve_mode_q <= mode_t'(cfg.curve_mode);
		end
	end

	// stage 1: sign and magnitude
	logic vld_s1, neg_s1;
	logic [SB-1:0] a_s1;
	mode_t mode_s1;
	logic [SB-1:0] a_c;
	assign a_c = src.sample_in[SB-1] ? (~src.sample_in + SB'(1)) : src.sample_in;

	// stage 2: curve prep
	logic vld_s2, neg_s2, pass_s2, big_s2;
	mode_t mode_s2;
	logic [SB-1:0] a_s2, e_s2, clip_s2;
	logic [SB:0] m_s2;
	logic [2*F-1:0] mm_s2;
	logic [15:0] lo_s2;
	logic [F+15:0] tprod_s2;

	logic [SB:0] m_c;
	logic [SB+2:0] p_c;
	logic ibig_c;
	logic [5:0] idx_c;
	logic [15:0] lo_c, hi_c;
	assign m_c = {a_s1, 1'b0};
	assign p_c = {a_s1, 3'b000} + {1'b0, a_s1, 2'b00};
	assign ibig_c = (64'(p_c) >> F) >= 64'(TANH_LAST);
	assign idx_c = {1'b0, p_c[F+4:F]};
	assign lo_c = ibig_c ? tanh_at(6'(TANH_LAST)) : tanh_at(idx_c);
	assign hi_c = ibig_c ? lo_c : tanh_at(idx_c + 6'd1);

	// stage 3: tape rounding, knee divisor, square
	logic vld_s3, neg_s3, pass_s3, big_s3;
	mode_t mode_s3;
	logic [SB-1:0] a_s3, e_s3, clip_s3;
	logic [DW-1:0] d_s3;
	logic [SB:0] m_s3;
	logic [F-1:0] s_s3, tape_s3;
	logic [AW-1:0] acc_c;
	assign acc_c = (AW'(lo_s2) << F) + AW'(tprod_s2) + AW'(32768);

	// stage 4: cube
	logic vld_s4, neg_s4, pass_s4, big_s4;
	mode_t mode_s4;
	logic [SB-1:0] a_s4, e_s4, clip_s4;
	logic [DW-1:0] d_s4;
	logic [SB:0] m_s4;
	logic [F-1:0] tape_s4;
	logic [2*F-1:0] sm_s4;

	// stage 5: divide by three
	logic vld_s5, neg_s5, pass_s5, big_s5;
	mode_t mode_s5;
	logic [SB-1:0] a_s5, e_s5, clip_s5;
	logic [DW-1:0] d_s5;
	logic [SB:0] m_s5;
	logic [F-1:0] tape_s5;
	logic [F+K3:0] q3p_s5;
	logic [F:0] qp1_c;
	assign qp1_c = (F + 1)'(sm_s4[2*F-1:F]) + (F + 1)'(1);

	// stage 6 select
	logic [F-1:0] tube_c;
	logic [SB-1:0] mag_c;
	assign tube_c = big_s5 ? F'(TUBE_MAX) : (m_s5[F-1:0] - q3p_s5[F+K3-1:K3]);
	always_comb begin
		unique case (mode_s5)
			MODE_KNEE: mag_c = a_s5;
			MODE_CLIP: mag_c = clip_s5;
			MODE_TUBE: mag_c = SB'(tube_c);
			MODE_TAPE: mag_c = SB'(tape_s5);
			default: mag_c = a_s5;
		endcase
	end

	// divider stages, index 0 is the select stage
	logic dv_vld_s [NQ+1];
	logic dv_neg_s [NQ+1];
	logic dv_div_s [NQ+1];
	logic [SB-1:0] dv_mag_s [NQ+1];
	logic [RW-1:0] dv_rem_s [NQ+1];
	logic [DW-1:0] dv_d_s [NQ+1];
	logic [NQ-1:0] dv_q_s [NQ+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			dv_vld_s[0] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= src.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			dv_vld_s[0] <= vld_s5;
			out_vld_q <= dv_vld_s[NQ];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= src.sample_in[SB-1];
			a_s1 <= a_c;
			mode_s1 <= curve_mode_q;

			neg_s2 <= neg_s1;
			mode_s2 <= mode_s1;
			a_s2 <= a_s1;
			pass_s2 <= a_s1 <= SB'(KNEE_T);
			e_s2 <= a_s1 - SB'(KNEE_T);
			clip_s2 <= (a_s1 > SB'(CLIP_C)) ? SB'(CLIP_C) : a_s1;
			m_s2 <= m_c;
			big_s2 <= m_c >= (SB + 1)'(ONE);
			mm_s2 <= m_c[F-1:0] * m_c[F-1:0];
			lo_s2 <= lo_c;
			tprod_s2 <= (hi_c - lo_c) * p_c[F-1:0];

			neg_s3 <= neg_s2;
			mode_s3 <= mode_s2;
			a_s3 <= a_s2;
			pass_s3 <= pass_s2;
			e_s3 <= e_s2;
			clip_s3 <= clip_s2;
			d_s3 <= DW'(ONE) + DW'(e_s2) + DW'({e_s2, 1'b0});
			m_s3 <= m_s2;
			big_s3 <= big_s2;
			s_s3 <= mm_s2[2*F-1:F];
			tape_s3 <= acc_c[F+15:16];

			neg_s4 <= neg_s3;
			mode_s4 <= mode_s3;
			a_s4 <= a_s3;
			pass_s4 <= pass_s3;
			e_s4 <= e_s3;
			clip_s4 <= clip_s3;
			d_s4 <= d_s3;
			m_s4 <= m_s3;
			big_s4 <= big_s3;
			tape_s4 <= tape_s3;
			sm_s4 <= s_s3 * m_s3[F-1:0];

			neg_s5 <= neg_s4;
			mode_s5 <= mode_s4;
			a_s5 <= a_s4;
			pass_s5 <= pass_s4;
			e_s5 <= e_s4;
			clip_s5 <= clip_s4;
			d_s5 <= d_s4;
			m_s5 <= m_s4;
			big_s5 <= big_s4;
			tape_s5 <= tape_s4;
			q3p_s5 <= qp1_c * K3'(M3);

			dv_neg_s[0] <= neg_s5;
			dv_div_s[0] <= (mode_s5 == MODE_KNEE) && !pass_s5;
			dv_mag_s[0] <= mag_c;
			dv_rem_s[0] <= RW'(e_s5) << F;
			dv_d_s[0] <= d_s5;
			dv_q_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= NQ; k++) begin : g_div
		localparam int J = NQ - k;
		logic [RW-1:0] sh;
		logic ge;
		assign sh = RW'(dv_d_s[k-1]) << J;
		assign ge = dv_rem_s[k-1] >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[k] <= dv_vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_neg_s[k] <= dv_neg_s[k-1];
				dv_div_s[k] <= dv_div_s[k-1];
				dv_mag_s[k] <= dv_mag_s[k-1];
				dv_d_s[k] <= dv_d_s[k-1];
				dv_rem_s[k] <= ge ? (dv_rem_s[k-1] - sh) : dv_rem_s[k-1];
				dv_q_s[k] <= dv_q_s[k-1] | (NQ'(ge) << J);
			end
		end
	end

	logic [SB-1:0] fin_c;
	assign fin_c = dv_div_s[NQ] ? (SB'(KNEE_T) + SB'(dv_q_s[NQ])) : dv_mag_s[NQ];

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= dv_neg_s[NQ] ? (~fin_c + SB'(1)) : fin_c;
		end
	end

	a_knee_quot: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_vld_s[NQ] && dv_div_s[NQ]) |-> (64'(dv_q_s[NQ]) <= ONE / 3))
		else $error("knee quotient out of range");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		dst.valid |-> (($signed(dst.sample_out) <= $signed(SB'(OUT_MAX)))
			&& ($signed(dst.sample_out) >= -$signed(SB'(OUT_MAX)))))
		else $error("output magnitude above knee limit");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_vld_s[NQ] && !adv) |=> (dv_vld_s[NQ] && $stable(dv_q_s[NQ])))
		else $error("divider output lost during stall");
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for the audio saturation waveshaper: directed samples in every curve mode, random samples in random modes
`timescale 1ns / 1ps
`default_nettype none
class shaper_scoreboard;
	logic signed [23:0] expected_q[$];
	int errors;
	int checked;

	function automatic logic [63:0] knee(logic [63:0] a);
		logic [63:0] t, e;
		t = (7 * 64'd1048576 + 5) / 10;
		if (a <= t) return a;
		e = a - t;
		return t + (e * 64'd1048576) / (64'd1048576 + 3 * e);
	endfunction

	function automatic logic [63:0] tube(logic [63:0] a);
		logic [63:0] m, s, q;
		m = 2 * a;
		if (m >= 64'd1048576) return (2 * 64'd1048576 + 1) / 3;
		s = (m * m) >> 20;
		q = (s * m) >> 20;
		return m - (q + 1) / 3;
	endfunction

	function automatic logic [63:0] tanh_lut(logic [5:0] k);
		logic [15:0] t[33] = '{0, 6520, 12841, 18788, 24228, 29077, 33300, 36904,
			39929, 42431, 44474, 46128, 47456, 48517, 49355, 50019,
			50543, 50954, 51277, 51529, 51727, 51881, 52002, 52096,
			52170, 52227, 52271, 52306, 52333, 52354, 52371, 52384, 52394};
		return 64'(t[k]);
	endfunction

	function automatic logic [63:0] tape(logic [63:0] a);
		logic [63:0] p, i, f, lo, hi, acc;
		p = 12 * a;
		i = p >> 20;
		f = p & 64'hFFFFF;
		if (i >= 32) begin
			acc = 64'd52394 * 64'd1048576;
		end else begin
			lo = tanh_lut(6'(i));
			hi = tanh_lut(6'(i + 1));
			acc = lo * 64'd1048576 + (hi - lo) * f;
		end
		return (acc + 32768) >> 16;
	endfunction

	function void note_sample(logic [23:0] x, asw_pkg::mode_t mode);
		logic [63:0] a, mag;
		logic neg;
		neg = x[23];
		a = neg ? {40'd0, -x} : {40'd0, x};
		if (neg && a == 0) a = 64'h800000;
		case (mode)
			asw_pkg::MODE_KNEE: mag = knee(a);
			asw_pkg::MODE_CLIP: mag = (a > 64'd996147) ? 64'd996147 : a;
			asw_pkg::MODE_TUBE: mag = tube(a);
			default: mag = tape(a);
		endcase
		expected_q.push_back(neg ? -mag[23:0] : mag[23:0]);
	endfunction

	function void check_sample(logic signed [23:0] got);
		logic signed [23:0] want;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected output beat %0d", $time, got);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		checked++;
		if (got !== want) begin
			$display("%0t: sample_out mismatch expected %0d actual %0d", $time, want, got);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import asw_pkg::*;
	logic clk = 0;
	logic arst_n = 0;
	asw_in_if src();
	asw_out_if dst();
	asw_cfg_if cfg();
	shaper_scoreboard sb = new();
	mode_t cur_mode = MODE_KNEE;
	int src_idle_pct = 0;
	int dst_stall_pct = 0;
	bit hold_dst = 0;
	int idle_cycles = 0;
	int samples_sent = 0;
	int mode_hits[4];

	audio_saturation_waveshaper i_dut (.clk(clk), .arst_n(arst_n), .src(src), .dst(dst),
		.cfg(cfg));

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	initial begin
		src.valid = 0;
		src.sample_in = 0;
		dst.ready = 0;
		cfg.valid = 0;
		cfg.curve_mode = MODE_KNEE;
	end

	// output side: sample at rising edge, change ready at falling edge
	always @(posedge clk) begin
		if (arst_n && dst.valid && dst.ready) sb.check_sample(dst.sample_out);
	end

	always @(negedge clk) begin
		if (!arst_n) dst.ready <= 0;
		else dst.ready <= !hold_dst && ($urandom_range(99) >= dst_stall_pct);
	end

	always @(posedge clk) begin
		if ((src.valid && src.ready) || (dst.valid && dst.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic send_sample(logic [23:0] x);
		while ($urandom_range(99) < src_idle_pct) begin
			src.valid <= 0;
			@(negedge clk);
		end
		src.valid <= 1;
		src.sample_in <= x;
		do @(posedge clk); while (!src.ready);
		sb.note_sample(x, cur_mode);
		mode_hits[cur_mode]++;
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		src.valid <= 0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_mode(mode_t m);
		cfg.curve_mode <= m;
		cfg.valid <= 1;
		do @(posedge clk); while (!cfg.ready);
		cur_mode = m;
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($urandom_range(2000000) - 1000000);
			2: return 24'($urandom_range(800000) - 400000);
			default: return 24'($urandom_range(16) - 8);
		endcase
	endfunction

	initial begin
		logic [23:0] edge_vals[16] = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF,
			24'h800000, 24'h800001, 24'd734003, 24'd734004, -24'd734004, 24'd996147,
			24'd996148, -24'd996148, 24'd524287, 24'd524288, -24'd524288, 24'd2796203};
		mode_t modes[4] = '{MODE_KNEE, MODE_CLIP, MODE_TUBE, MODE_TAPE};
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (modes[m]) begin
			write_mode(modes[m]);
			foreach (edge_vals[k]) send_sample(edge_vals[k]);
			drain();
		end
		// long receiver hold while input keeps coming
		hold_dst = 1;
		fork
			begin
				repeat (200) @(negedge clk);
				hold_dst = 0;
			end
			for (int k = 0; k < 40; k++) send_sample(rand_sample());
		join
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = (ph == 1 || ph == 3) ? 48 : (ph == 3 ? 8 : 0);
			dst_stall_pct = (ph >= 2) ? 48 : 0;
			if (ph == 3) begin
				src_idle_pct = 8;
				dst_stall_pct = 8;
			end
			for (int r = 0; r < 4; r++) begin
				write_mode(mode_t'($urandom_range(3)));
				for (int k = 0; k < 22; k++) send_sample(rand_sample());
				drain();
			end
		end
		drain();
		$display("tb_top: %0d samples checked, per mode knee %0d clip %0d tube %0d tape %0d",
			sb.checked, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		$display("tb_top: directed edges, long output hold and four idle/stall phases");
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
